@@ rtl/build_script_tokenizer_unit_macros.svh @@
// assertion macros shared by the tokenizer rtl
`ifndef BUILD_SCRIPT_TOKENIZER_UNIT_MACROS_SVH
`define BUILD_SCRIPT_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define BSTOK_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off while arst_n is low
`define BSTOK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bstok_pkg.sv @@
// types, character codes and helpers for the build script tokenizer
`default_nettype none
package bstok_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_NUMBER  = 3'd1,
		MODE_IDENT   = 3'd2,
		MODE_STRING  = 3'd3,
		MODE_COMMENT = 3'd4,
		MODE_DISCARD = 3'd5
	} lex_mode_t;

	typedef enum logic [2:0] {
		KIND_NUMBER      = 3'd0,
		KIND_IDENT_CHAR  = 3'd1,
		KIND_IDENT_END   = 3'd2,
		KIND_STRING_CHAR = 3'd3,
		KIND_STRING_END  = 3'd4,
		KIND_PUNCT       = 3'd5,
		KIND_ERROR       = 3'd6
	} token_kind_t;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned PUNCT_COUNT = 6;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_UNDER   = 8'h5f;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	// punct code is the index into this table
	localparam logic [7:0] PUNCT_CHARS [PUNCT_COUNT] = '{
		8'h3d, 8'h28, 8'h29, 8'h5b, 8'h5d, 8'h2c
	};

	typedef struct packed {
		token_kind_t          kind;
		logic [7:0]           char_code;
		logic [2:0]           punct_code;
		logic [VALUE_W-1:0]   number_value;
		logic                 number_saturated;
		logic                 first_char;
		logic                 unterminated;
		logic                 last_of_run;
	} tok_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_ident_start(input logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a))
			|| (b == CH_UNDER);
	endfunction

	function automatic logic is_quote(input logic [7:0] b);
		return (b == CH_DQUOTE) || (b == CH_SQUOTE);
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NEWLINE);
	endfunction

endpackage
`default_nettype wire

@@ rtl/build_script_tokenizer_unit.sv @@
// build script tokenizer: one text byte in, zero to three tokens out
// a token is registered in the token queue before it appears on the master side
// throughput: one byte per cycle while each byte yields at most one token and m_axis_tready stays high
// a byte yielding two or three tokens stalls the input while they drain;
// the 4-entry token queue takes a new byte only while it holds at most one token
// reset: arst_n clears the lexer state and empties the queue at once
`default_nettype none
module build_script_tokenizer_unit
	import bstok_pkg::*;
#(
	parameter int unsigned NUMBER_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] text_byte
	input  wire logic        s_axis_tlast,  // end_of_text
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] char_code, [10:8] punct_code, [42:11] number_value,
	// [43] number_saturated, [44] first_char, [45] unterminated, [47:46] zero
	output logic [47:0]      m_axis_tdata,
	output logic [2:0]       m_axis_tuser,  // [2:0] token_kind
	output logic             m_axis_tlast   // last_of_run
);

	`include "build_script_tokenizer_unit_macros.svh"

	localparam int unsigned NB = NUMBER_BITS;

	lex_mode_t          mode_q, mode_d;
	logic [NB-1:0]      acc_q, acc_d;
	logic               sat_q, sat_d;
	logic               empty_q, empty_d;

	tok_t               fifo_q [4];
	logic [1:0]         wr_ptr_q, rd_ptr_q;
	logic [2:0]         count_q;

	tok_t               res [3];
	logic [1:0]         n_res;
	logic [1:0]         n_push;
	logic               accept, pop;
	tok_t               head;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign pop    = m_axis_tvalid && m_axis_tready;
	assign n_push = accept ? n_res : 2'd0;

	always_comb begin
		logic [7:0]      b;
		logic [1:0]      n_v;
		logic            run_idle;
		logic            hit;
		logic [NB+3:0]   prod;
		logic [NB+31:0]  acc_ext;
		tok_t            blank;
		b        = s_axis_tdata;
		n_v      = 2'd0;
		run_idle = 1'b0;
		hit      = 1'b0;
		prod     = '0;
		blank    = '0;
		for (int i = 0; i < 3; i++) begin
			res[i] = blank;
		end
		mode_d  = mode_q;
		acc_d   = acc_q;
		sat_d   = sat_q;
		empty_d = empty_q;
		acc_ext = {{VALUE_W{1'b0}}, acc_q};

		unique case (mode_q)
			MODE_NUMBER: begin
				if (is_digit(b)) begin
					prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (NB + 4)'(b[3:0]);
					if (sat_q || (prod[NB+3:NB] != 4'd0)) begin
						acc_d = '1;
						sat_d = 1'b1;
					end else begin
						acc_d = prod[NB-1:0];
					end
				end else begin
					res[n_v].kind             = KIND_NUMBER;
					res[n_v].number_value     = acc_ext[VALUE_W-1:0];
					res[n_v].number_saturated = sat_q;
					n_v = n_v + 2'd1;
					run_idle = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (is_ident_start(b) || is_digit(b)) begin
					res[n_v].kind      = KIND_IDENT_CHAR;
					res[n_v].char_code = b;
					n_v = n_v + 2'd1;
				end else begin
					res[n_v].kind = KIND_IDENT_END;
					n_v = n_v + 2'd1;
					run_idle = 1'b1;
				end
			end
			MODE_STRING: begin
				if (is_quote(b)) begin
					res[n_v].kind = KIND_STRING_END;
					n_v = n_v + 2'd1;
					mode_d = MODE_IDLE;
				end else begin
					res[n_v].kind       = KIND_STRING_CHAR;
					res[n_v].char_code  = b;
					res[n_v].first_char = empty_q;
					n_v = n_v + 2'd1;
					empty_d = 1'b0;
				end
			end
			MODE_COMMENT: begin
				if (b == CH_NEWLINE) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_DISCARD: begin
			end
			default: begin
				run_idle = 1'b1;
			end
		endcase

		// byte handled as the start of a new token
		if (run_idle) begin
			mode_d = MODE_IDLE;
			if (is_blank(b)) begin
			end else if (b == CH_HASH) begin
				mode_d = MODE_COMMENT;
			end else if (is_digit(b)) begin
				acc_d  = NB'(b[3:0]);
				sat_d  = 1'b0;
				mode_d = MODE_NUMBER;
			end else if (is_quote(b)) begin
				empty_d = 1'b1;
				mode_d  = MODE_STRING;
			end else if (is_ident_start(b)) begin
				res[n_v].kind       = KIND_IDENT_CHAR;
				res[n_v].char_code  = b;
				res[n_v].first_char = 1'b1;
				n_v = n_v + 2'd1;
				mode_d = MODE_IDENT;
			end else begin
				for (int i = 0; i < PUNCT_COUNT; i++) begin
					if (b == PUNCT_CHARS[i]) begin
						hit = 1'b1;
						res[n_v].kind       = KIND_PUNCT;
						res[n_v].punct_code = 3'(i);
					end
				end
				if (!hit) begin
					res[n_v].kind      = KIND_ERROR;
					res[n_v].char_code = b;
					mode_d = MODE_DISCARD;
				end
				n_v = n_v + 2'd1;
			end
		end

		// end of text closes whatever is still open
		if (s_axis_tlast) begin
			acc_ext = {{VALUE_W{1'b0}}, acc_d};
			if (mode_d == MODE_NUMBER) begin
				res[n_v].kind             = KIND_NUMBER;
				res[n_v].number_value     = acc_ext[VALUE_W-1:0];
				res[n_v].number_saturated = sat_d;
				n_v = n_v + 2'd1;
			end else if (mode_d == MODE_IDENT) begin
				res[n_v].kind = KIND_IDENT_END;
				n_v = n_v + 2'd1;
			end else if (mode_d == MODE_STRING) begin
				res[n_v].kind         = KIND_STRING_END;
				res[n_v].unterminated = 1'b1;
				n_v = n_v + 2'd1;
			end
			mode_d  = MODE_IDLE;
			acc_d   = '0;
			sat_d   = 1'b0;
			empty_d = 1'b1;
		end

		if (n_v != 2'd0) begin
			res[n_v - 2'd1].last_of_run = 1'b1;
		end
		n_res = n_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_q   <= '0;
			sat_q   <= 1'b0;
			empty_q <= 1'b1;
		end else if (accept) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			sat_q   <= sat_d;
			empty_q <= empty_d;
		end
	end

	// token queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, n_push} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < n_push) begin
				fifo_q[wr_ptr_q + 2'(i)] <= res[i];
			end
		end
	end

	assign s_axis_tready = (count_q <= 3'd1);
	assign head          = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = (count_q != 3'd0);
	assign m_axis_tdata  = {2'b00, head.unterminated, head.first_char, head.number_saturated,
		head.number_value, head.punct_code, head.char_code};
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last_of_run;

	`BSTOK_ASSERT_SAME(a_queue_bound, 1'b1, count_q <= 3'd4, "token queue overflow")
	`BSTOK_ASSERT_SAME(a_accept_room, accept, count_q <= 3'd1, "byte taken without room")
	`BSTOK_ASSERT_NEXT(a_eot_resets, accept && s_axis_tlast,
		mode_q == MODE_IDLE && acc_q == '0 && !sat_q && empty_q, "state not cleared at end of text")
	`BSTOK_ASSERT_SAME(a_discard_quiet, accept && mode_q == MODE_DISCARD, n_push == 2'd0,
		"token emitted while discarding")

endmodule
`default_nettype wire
